// File: src/kabf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_pkg: shared types and constants for the angle/bias Kalman filter
// Holds field widths, reset values, register indexes and the controller
// command and status structs.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int NUM_AXES   = 2;
    localparam int AXIS_W     = 1;
    localparam int MEAS_W     = 25;
    localparam int GYRO_W     = 28;
    localparam int DT_W       = 24;
    localparam int BIAS_W     = 28;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 64;

    localparam logic [31:0] Q_ANGLE_RESET    = 32'd4294967;
    localparam logic [31:0] Q_BIAS_RESET     = 32'd12884902;
    localparam logic [31:0] MEAS_NOISE_RESET = 32'd128849019;
    localparam logic signed [31:0] BIAS_LIMIT = 32'sd131072000;

    localparam logic [1:0] REG_Q_ANGLE    = 2'd0;
    localparam logic [1:0] REG_Q_BIAS     = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

    // datapath operation codes, one per step
    typedef enum logic [4:0] {
        OP_LOAD   = 5'd0,
        OP_RATE   = 5'd1,
        OP_A      = 5'd2,
        OP_D2     = 5'd3,
        OP_T1     = 5'd4,
        OP_P00    = 5'd5,
        OP_P01    = 5'd6,
        OP_P11    = 5'd7,
        OP_DIVS   = 5'd8,
        OP_K0     = 5'd9,
        OP_K1     = 5'd10,
        OP_Y      = 5'd11,
        OP_ANG    = 5'd12,
        OP_BIAS   = 5'd13,
        OP_C00    = 5'd14,
        OP_C01    = 5'd15,
        OP_C10    = 5'd16,
        OP_C11    = 5'd17,
        OP_STORE  = 5'd18
    } op_t;

    typedef struct packed {
        logic op_valid;
        op_t  op;
        logic div_start;
        logic div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic axis_bad;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: src/kabf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_div: iterative signed divider
// Restoring radix-2, one quotient bit per cycle, 61-bit dividend, truncation.
// ----------------------------------------------------------------------------
module kabf_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [60:0] dividend,
    input  wire logic signed [33:0] divisor,
    output logic                    busy,
    output logic signed [61:0]      quotient
);

    logic [60:0] rem_q_reg, rem_q_next;
    logic [33:0] part_reg, part_next;
    logic [33:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [34:0] trial;
    logic [60:0] abs_n;

    always_comb begin
        abs_n = dividend[60] ? 61'(-dividend) : 61'(dividend);
        trial = {part_reg, rem_q_reg[60]} - {1'b0, den_reg};
        rem_q_next = rem_q_reg;
        part_next  = part_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        busy_next  = busy_reg;
        if (start) begin
            rem_q_next = abs_n;
            part_next  = '0;
            den_next   = divisor[33] ? 34'(-divisor) : 34'(divisor);
            neg_next   = dividend[60] ^ divisor[33];
            cnt_next   = 6'd61;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!trial[34]) begin
                part_next = trial[33:0];
            end else begin
                part_next = {part_reg[32:0], rem_q_reg[60]};
            end
            rem_q_next = {rem_q_reg[59:0], ~trial[34]};
            cnt_next   = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_q_reg <= rem_q_next;
        part_reg  <= part_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed({1'b0, rem_q_reg}) : $signed({1'b0, rem_q_reg});

endmodule
`default_nettype wire

// File: src/kabf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_datapath: state, registers and shared multiplier of the filter
// One operation per command; a shared 33x33 product feeds a registered
// shift/saturate stage. Per-axis state lives in flip-flops.
// ----------------------------------------------------------------------------
module kabf_datapath (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_load,
    input  wire logic [kabf_pkg::IN_DATA_W-1:0] in_word,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_idx,
    input  wire logic [31:0]              cfg_data,
    input  wire kabf_pkg::dp_cmd_t        cmd,
    output kabf_pkg::dp_stat_t            stat,
    output logic                          res_axis,
    output logic signed [31:0]            res_angle,
    output logic signed [27:0]            res_bias
);

    localparam int AXN = kabf_pkg::NUM_AXES;

    logic [31:0] qa_reg, qb_reg, rm_reg;
    logic signed [31:0] ang_reg [AXN];
    logic signed [31:0] bia_reg [AXN];
    logic signed [31:0] paa_reg [AXN];
    logic signed [31:0] pab_reg [AXN];
    logic signed [31:0] pba_reg [AXN];
    logic signed [31:0] pbb_reg [AXN];

    logic                axis_reg;
    logic signed [24:0]  meas_reg;
    logic signed [27:0]  gyro_reg;
    logic [23:0]         dt_reg;
    logic signed [32:0]  rate_reg;
    logic signed [31:0]  a_reg, d2_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [33:0]  t1_reg;
    logic signed [31:0]  k0_reg, k1_reg, y_reg, nang_reg, nbia_reg;
    logic signed [31:0]  c00_reg, c01_reg, c10_reg, c11_reg;

    logic signed [32:0]  ma, mb;
    logic signed [65:0]  prod;
    logic signed [65:0]  sh24, sh28;
    logic signed [61:0]  quot;
    logic                div_busy;
    logic signed [60:0]  div_n;
    logic signed [33:0]  div_d;
    logic signed [33:0]  s_val;
    logic                ax_ok;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7fffffff;
        if (v < -68'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    assign ax_ok = 32'(axis_reg) < 32'(AXN);
    assign s_val = 34'(p00_reg) + 34'($signed({1'b0, rm_reg[31:4]}));

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            kabf_pkg::OP_A:   begin ma = 33'(dt_reg);  mb = rate_reg; end
            kabf_pkg::OP_D2:  begin ma = 33'(dt_reg);  mb = 33'(dt_reg); end
            kabf_pkg::OP_T1:  begin ma = 33'(d2_reg);  mb = 33'(p11_reg); end
            kabf_pkg::OP_P00: begin ma = 33'(dt_reg);  mb = 33'(t1_reg); end
            kabf_pkg::OP_P01: begin ma = 33'(dt_reg);  mb = 33'(p11_reg); end
            kabf_pkg::OP_P11: begin ma = 33'(dt_reg);  mb = 33'({1'b0, qb_reg[31:4]}); end
            kabf_pkg::OP_ANG: begin ma = 33'(k0_reg);  mb = 33'(y_reg); end
            kabf_pkg::OP_BIAS:begin ma = 33'(k1_reg);  mb = 33'(y_reg); end
            kabf_pkg::OP_C00: begin ma = 33'(k0_reg);  mb = 33'(p00_reg); end
            kabf_pkg::OP_C01: begin ma = 33'(k0_reg);  mb = 33'(p01_reg); end
            kabf_pkg::OP_C10: begin ma = 33'(k1_reg);  mb = 33'(p00_reg); end
            kabf_pkg::OP_C11: begin ma = 33'(k1_reg);  mb = 33'(p01_reg); end
            default: ;
        endcase
        prod = ma * mb;
        sh24 = prod >>> 24;
        sh28 = prod >>> 28;
    end

    // t1 is 34 bits wide; dt*t1 uses its own 25x34 product
    logic signed [58:0] pt1;
    assign pt1 = $signed({1'b0, dt_reg}) * t1_reg;

    assign div_n = cmd.div_sel ? $signed({p10_reg[31], p10_reg, 28'd0})
                               : $signed({p00_reg[31], p00_reg, 28'd0});
    assign div_d = s_val;

    kabf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(div_n),
        .divisor (div_d),
        .busy    (div_busy),
        .quotient(quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= kabf_pkg::Q_ANGLE_RESET;
            qb_reg <= kabf_pkg::Q_BIAS_RESET;
            rm_reg <= kabf_pkg::MEAS_NOISE_RESET;
            for (int i = 0; i < AXN; i++) begin
                ang_reg[i] <= '0; bia_reg[i] <= '0;
                paa_reg[i] <= '0; pab_reg[i] <= '0;
                pba_reg[i] <= '0; pbb_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    kabf_pkg::REG_Q_ANGLE:    qa_reg <= cfg_data;
                    kabf_pkg::REG_Q_BIAS:     qb_reg <= cfg_data;
                    kabf_pkg::REG_MEAS_NOISE: rm_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op_valid && cmd.op == kabf_pkg::OP_STORE && ax_ok) begin
                ang_reg[axis_reg] <= nang_reg;
                bia_reg[axis_reg] <= nbia_reg;
                paa_reg[axis_reg] <= c00_reg;
                pab_reg[axis_reg] <= c01_reg;
                pba_reg[axis_reg] <= c10_reg;
                pbb_reg[axis_reg] <= c11_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            axis_reg <= in_word[0];
            meas_reg <= in_word[25:1];
            gyro_reg <= in_word[53:26];
            dt_reg   <= in_word[77:54];
        end
        if (cmd.op_valid) begin
            unique case (cmd.op)
                kabf_pkg::OP_LOAD: begin
                    p00_reg <= paa_reg[axis_reg];
                    p01_reg <= pab_reg[axis_reg];
                    p10_reg <= pba_reg[axis_reg];
                    p11_reg <= pbb_reg[axis_reg];
                end
                kabf_pkg::OP_RATE: rate_reg <= 33'(gyro_reg) - 33'(bia_reg[axis_reg]);
                kabf_pkg::OP_A:
                    a_reg <= sat32(68'(ang_reg[axis_reg]) + 68'(sh24));
                kabf_pkg::OP_D2:   d2_reg <= sh24[31:0];
                kabf_pkg::OP_T1:
                    t1_reg <= 34'(sh24) - 34'(p01_reg) - 34'(p10_reg)
                              + 34'($signed({1'b0, qa_reg[31:4]}));
                kabf_pkg::OP_P00:
                    p00_reg <= sat32(68'(p00_reg) + 68'(pt1 >>> 24));
                kabf_pkg::OP_P01: begin
                    p01_reg <= sat32(68'(p01_reg) - 68'(sh24));
                    p10_reg <= sat32(68'(p10_reg) - 68'(sh24));
                end
                kabf_pkg::OP_P11:
                    p11_reg <= sat32(68'(p11_reg) + 68'(sh24));
                kabf_pkg::OP_DIVS: begin
                    k0_reg <= '0;
                    k1_reg <= '0;
                end
                kabf_pkg::OP_K0: if (s_val > 0) k0_reg <= sat32(68'(quot));
                kabf_pkg::OP_K1: if (s_val > 0) k1_reg <= sat32(68'(quot));
                kabf_pkg::OP_Y:
                    y_reg <= sat32(68'(meas_reg) - 68'(a_reg));
                kabf_pkg::OP_ANG:
                    nang_reg <= sat32(68'(a_reg) + 68'(sh28));
                kabf_pkg::OP_BIAS: begin
                    if (68'(bia_reg[axis_reg]) + 68'(sh28) > 68'(kabf_pkg::BIAS_LIMIT))
                        nbia_reg <= kabf_pkg::BIAS_LIMIT;
                    else if (68'(bia_reg[axis_reg]) + 68'(sh28) < -68'(kabf_pkg::BIAS_LIMIT))
                        nbia_reg <= -kabf_pkg::BIAS_LIMIT;
                    else
                        nbia_reg <= 32'(68'(bia_reg[axis_reg]) + 68'(sh28));
                end
                kabf_pkg::OP_C00: c00_reg <= sat32(68'(p00_reg) - 68'(sh28));
                kabf_pkg::OP_C01: c01_reg <= sat32(68'(p01_reg) - 68'(sh28));
                kabf_pkg::OP_C10: c10_reg <= sat32(68'(p10_reg) - 68'(sh28));
                kabf_pkg::OP_C11: c11_reg <= sat32(68'(p11_reg) - 68'(sh28));
                default: ;
            endcase
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.axis_bad = !ax_ok;
    assign res_axis  = axis_reg;
    assign res_angle = ax_ok ? nang_reg : '0;
    assign res_bias  = ax_ok ? nbia_reg[27:0] : '0;

endmodule
`default_nettype wire

// File: src/kabf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_ctrl: sequencer for the filter datapath
// Steps through the operation list once per word, waits on the divider twice.
// ----------------------------------------------------------------------------
module kabf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire kabf_pkg::dp_stat_t stat,
    input  wire logic               out_free,
    output kabf_pkg::dp_cmd_t       cmd,
    output logic                    idle,
    output logic                    done
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    kabf_pkg::op_t op_reg, op_next;
    logic sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        sel_next   = sel_reg;
        cmd        = '{op_valid: 1'b0, op: op_reg, div_start: 1'b0, div_sel: sel_reg};
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_RUN;
                    op_next    = kabf_pkg::OP_LOAD;
                end
            end
            S_RUN: begin
                cmd.op_valid = 1'b1;
                if (op_reg == kabf_pkg::OP_DIVS) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b0;
                    sel_next   = 1'b0;
                    state_next = S_DIV;
                end else if (op_reg == kabf_pkg::OP_STORE) begin
                    state_next = S_WAIT;
                end else begin
                    op_next = kabf_pkg::op_t'(op_reg + 5'd1);
                end
            end
            S_DIV: begin
                if (!stat.div_busy) begin
                    if (!sel_reg) begin
                        cmd.op_valid  = 1'b1;
                        cmd.op        = kabf_pkg::OP_K0;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = 1'b1;
                        sel_next      = 1'b1;
                    end else begin
                        cmd.op_valid = 1'b1;
                        cmd.op       = kabf_pkg::OP_K1;
                        op_next      = kabf_pkg::OP_Y;
                        state_next   = S_RUN;
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= kabf_pkg::OP_LOAD;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sel_reg   <= sel_next;
        end
    end

    assign idle = state_reg == S_IDLE;

    a_one_state: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start && idle |=> state_reg == S_RUN) else $error("start lost");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> state_reg == S_DIV) else $error("divider not awaited");

endmodule
`default_nettype wire

// File: src/kalman_angle_bias_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state angle/gyro-bias Kalman filter
// Each word runs through 19 sequencer steps, two runs of the iterative divider
// and the hand-off to the output before m_tvalid rises.
// Words are taken one at a time while idle; a held result stalls the final hand-off.
// The next word is taken while a result waits in the output register.
// Synchronous active-low reset clears state and covariance, loads noise defaults.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // axis, measured_angle, gyro_rate, time_step
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // axis_out, filtered_angle, estimated_bias
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    kabf_pkg::dp_cmd_t  cmd;
    kabf_pkg::dp_stat_t stat;
    logic idle, done, accept;
    logic res_axis;
    logic signed [31:0] res_angle;
    logic signed [27:0] res_bias;
    logic        ov_reg;
    logic [63:0] od_reg;

    assign s_tready  = idle;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    kabf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .stat    (stat),
        .out_free(!ov_reg || m_tready),
        .cmd     (cmd),
        .idle    (idle),
        .done    (done)
    );

    kabf_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_load  (accept),
        .in_word  (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .res_axis (res_axis),
        .res_angle(res_angle),
        .res_bias (res_bias)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (done) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
        if (done) begin
            od_reg <= {3'd0, res_bias, res_angle, res_axis};
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (!ov_reg || m_tready)) else $error("overwrite");
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !idle |-> !accept) else $error("accept while busy");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the angle/bias Kalman filter
// Drives sensor words with bursty gaps, stalls the result side, predicts the
// filtered angle and bias per axis in fixed point, and checks every result
// word in order. Noise registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [79:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    kalman_angle_bias_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic        axis_out;
        logic [31:0] filtered_angle;
        logic [27:0] estimated_bias;
    } est_t;

    est_t    est_q[$];
    int      n_err = 0;
    longint  cycles = 0;
    int      stall_mode = 0;

    logic [31:0] q_angle_r, q_bias_r, r_meas_r;
    longint ang_st[kabf_pkg::NUM_AXES], bias_st[kabf_pkg::NUM_AXES];
    longint paa[kabf_pkg::NUM_AXES], pab[kabf_pkg::NUM_AXES];
    longint pba[kabf_pkg::NUM_AXES], pbb[kabf_pkg::NUM_AXES];

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic filter_reset();
        q_angle_r = kabf_pkg::Q_ANGLE_RESET;
        q_bias_r  = kabf_pkg::Q_BIAS_RESET;
        r_meas_r  = kabf_pkg::MEAS_NOISE_RESET;
        for (int i = 0; i < kabf_pkg::NUM_AXES; i++) begin
            ang_st[i] = 0; bias_st[i] = 0;
            paa[i] = 0; pab[i] = 0; pba[i] = 0; pbb[i] = 0;
        end
    endtask

    function automatic est_t kalman_update(logic ax, logic signed [24:0] meas_in,
                                           logic signed [27:0] gyro_in,
                                           logic [23:0] dt_in);
        est_t   r;
        longint meas, gyro, dt, qa, qb, rm, rate, a, d2;
        longint p00, p01, p10, p11, s, k0, k1, y;
        int     i;
        meas = meas_in; gyro = gyro_in; dt = dt_in;
        qa = q_angle_r >> 4; qb = q_bias_r >> 4; rm = r_meas_r >> 4;
        r.axis_out = ax;
        i = ax;
        if (i >= kabf_pkg::NUM_AXES) begin
            r.filtered_angle = '0; r.estimated_bias = '0;
            return r;
        end
        rate = gyro - bias_st[i];
        a = sat32(ang_st[i] + fshr(dt * rate, 24));
        d2 = fshr(dt * dt, 24);
        p00 = paa[i]; p01 = pab[i]; p10 = pba[i]; p11 = pbb[i];
        p00 = sat32(p00 + fshr(dt * (fshr(d2 * p11, 24) - p01 - p10 + qa), 24));
        p01 = sat32(p01 - fshr(dt * p11, 24));
        p10 = sat32(p10 - fshr(dt * p11, 24));
        p11 = sat32(p11 + fshr(dt * qb, 24));
        s = p00 + rm;
        if (s > 0) begin
            k0 = sat32((p00 <<< 28) / s);
            k1 = sat32((p10 <<< 28) / s);
        end else begin
            k0 = 0; k1 = 0;
        end
        y = sat32(meas - a);
        ang_st[i] = sat32(a + fshr(k0 * y, 28));
        bias_st[i] = bias_st[i] + fshr(k1 * y, 28);
        if (bias_st[i] > kabf_pkg::BIAS_LIMIT) bias_st[i] = kabf_pkg::BIAS_LIMIT;
        if (bias_st[i] < -kabf_pkg::BIAS_LIMIT) bias_st[i] = -kabf_pkg::BIAS_LIMIT;
        paa[i] = sat32(p00 - fshr(k0 * p00, 28));
        pab[i] = sat32(p01 - fshr(k0 * p01, 28));
        pba[i] = sat32(p10 - fshr(k1 * p00, 28));
        pbb[i] = sat32(p11 - fshr(k1 * p01, 28));
        r.filtered_angle = ang_st[i][31:0];
        r.estimated_bias = bias_st[i][27:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_err++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (m_tvalid && m_tready) begin
            if (est_q.size() == 0) begin
                report("unexpected word", m_tdata[31:0], '0);
            end else begin
                est_t e;
                e = est_q.pop_front();
                if (m_tdata[0] !== e.axis_out)
                    report("axis_out", m_tdata[0], e.axis_out);
                if (m_tdata[32:1] !== e.filtered_angle)
                    report("filtered_angle", m_tdata[32:1], e.filtered_angle);
                if (m_tdata[60:33] !== e.estimated_bias)
                    report("estimated_bias", m_tdata[60:33], e.estimated_bias);
            end
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 1) == 0) ? 1'b1 : (cycles % 7 < 2);
        endcase
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_word(logic ax, logic [24:0] meas, logic [27:0] gyro,
                             logic [23:0] dt);
        int gap;
        gap = 1;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 40);
        end
        burst_left--;
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {2'b0, dt, gyro, meas, ax};
        est_q.push_back(kalman_update(ax, meas, gyro, dt));
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (est_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            kabf_pkg::REG_Q_ANGLE:    q_angle_r = val;
            kabf_pkg::REG_Q_BIAS:     q_bias_r = val;
            kabf_pkg::REG_MEAS_NOISE: r_meas_r = val;
            default: ;
        endcase
    endtask

    task automatic send_random(int n, bit wide);
        logic [24:0] meas;
        logic [27:0] gyro;
        logic [23:0] dt;
        for (int k = 0; k < n; k++) begin
            if (wide && $urandom_range(0, 9) == 0) begin
                meas = 25'($urandom); gyro = 28'($urandom); dt = 24'($urandom);
            end else begin
                meas = 25'($signed($urandom_range(0, 23592960)) - 11796480);
                gyro = 28'($signed($urandom_range(0, 262144000)) - 131072000);
                dt = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                 : 24'($urandom_range(0, 400000));
            end
            send_word(1'($urandom_range(0, 1)), meas, gyro, dt);
        end
    endtask

    task automatic test_directed();
        send_word(1'b0, 25'd0, 28'd0, 24'd0);
        send_word(1'b1, 25'd11796480, 28'd131072000, 24'hFFFFFF);
        send_word(1'b0, -25'sd11796480, -28'sd131072000, 24'hFFFFFF);
        send_word(1'b1, 25'h0FFFFFF, 28'h7FFFFFF, 24'd1);
        send_word(1'b0, 25'h1000000, 28'h8000000, 24'd16384);
        send_word(1'b1, 25'h1FFFFFF, 28'hFFFFFFF, 24'd0);
        for (int k = 0; k < 8; k++)
            send_word(k[0], 25'd655360, 28'd0, 24'd16777);
        drain();
    endtask

    // zero measurement noise collapses P00, so a following zero time step
    // sees a zero innovation variance
    task automatic test_zero_variance();
        write_reg(kabf_pkg::REG_Q_ANGLE, 32'd0);
        write_reg(kabf_pkg::REG_MEAS_NOISE, 32'd0);
        write_reg(REG_UNUSED, 32'hDEADBEEF);
        send_word(1'b0, 25'd100000, 28'd5000, 24'd0);
        send_word(1'b0, 25'd100000, 28'd5000, 24'd0);
        send_word(1'b0, 25'd100000, 28'd5000, 24'd1000);
        drain();
    endtask

    task automatic test_config_sweep();
        logic [31:0] vals[4] = '{32'd0, 32'hFFFFFFFF, 32'd16, 32'h00F00000};
        for (int p = 0; p < 4; p++) begin
            write_reg(kabf_pkg::REG_Q_ANGLE, vals[p]);
            write_reg(kabf_pkg::REG_Q_BIAS, vals[(p + 1) % 4]);
            write_reg(kabf_pkg::REG_MEAS_NOISE, vals[(p + 2) % 4]);
            stall_mode = p % 3;
            send_random(150, 1'b1);
            drain();
        end
        write_reg(kabf_pkg::REG_Q_ANGLE, kabf_pkg::Q_ANGLE_RESET);
        write_reg(kabf_pkg::REG_Q_BIAS, kabf_pkg::Q_BIAS_RESET);
        write_reg(kabf_pkg::REG_MEAS_NOISE, kabf_pkg::MEAS_NOISE_RESET);
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            stall_mode = p % 3;
            send_random(200, 1'b1);
            // sender holds off until every result is back
            while (est_q.size() != 0) @(posedge aclk);
            send_random(20, 1'b0);
        end
        drain();
    endtask

    initial begin
        filter_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_zero_variance();
        test_config_sweep();
        test_random();
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
